FILE: sv/lts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line token splitter package
// Shared types, character codes and the byte classifier for the token
// splitter and its checker.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Default widths of the column and line counters.
  localparam int unsigned ColBitsDefault  = 16;
  localparam int unsigned LineBitsDefault = 32;

  // Token classes; the none code marks "no open token".
  typedef enum logic [2:0] {
    CL_NUM  = 3'd0,
    CL_NAME = 3'd1,
    CL_OP   = 3'd2,
    CL_STR  = 3'd3,
    CL_NONE = 3'd4
  } class_e;

  // Character codes that steer the splitter.
  localparam logic [7:0] ChMinus    = 8'h2D;
  localparam logic [7:0] ChGreater  = 8'h3E;
  localparam logic [7:0] ChEqual    = 8'h3D;
  localparam logic [7:0] ChLParen   = 8'h28;
  localparam logic [7:0] ChRParen   = 8'h29;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChPlus     = 8'h2B;
  localparam logic [7:0] ChLBrace   = 8'h7B;
  localparam logic [7:0] ChRBrace   = 8'h7D;
  localparam logic [7:0] ChAmp      = 8'h26;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChQuote    = 8'h27;
  localparam logic [7:0] ChDblQuote = 8'h22;

  // One input item: a character byte or an end-of-line marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_t;

  // One result item.
  typedef struct packed {
    logic        token_done;
    logic [1:0]  token_class;
    logic [31:0] token_line;
    logic [15:0] token_column;
    logic        text_cleared;
    logic        char_kept;
  } out_t;

  // Classify one byte as digit, letter, operator or none.
  function automatic class_e byte_class(input logic [7:0] c);
    class_e cls;
    if (c inside {[8'h30:8'h39]}) begin
      cls = CL_NUM;
    end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      cls = CL_NAME;
    end else if (c inside {ChMinus, ChGreater, ChEqual, ChLParen, ChRParen,
                           ChComma, ChPlus, ChLBrace, ChRBrace, ChAmp}) begin
      cls = CL_OP;
    end else begin
      cls = CL_NONE;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

FILE: sv/line_token_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line token splitter
// Splits a byte stream into number, name, operator and string tokens and
// reports, per item, the token that closes and how the open text changes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid_i/in_ready_o   | in_data_i  (lts_pkg::in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (lts_pkg::out_t)
//
//  One item per cycle while the output is not stalled: the class decode and
//  token state update are combinational between the state and result registers.
//  A result is registered and appears in the cycle after its item is accepted.
//  The input is ready whenever the result register is empty or being taken,
//  so a stalled output holds at most one result and stops the input.
//  Reset opens line 1 with no open token and an empty result register.
// ----------------------------------------------------------------------------
module line_token_splitter #(
  parameter int unsigned COL_BITS  = lts_pkg::ColBitsDefault,
  parameter int unsigned LINE_BITS = lts_pkg::LineBitsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire lts_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output lts_pkg::out_t     out_data_o
);

  // Token state.
  lts_pkg::class_e        open_class_q, open_class_d;
  logic [COL_BITS-1:0]    open_col_q, open_col_d;
  logic [COL_BITS-1:0]    char_idx_q, char_idx_d;
  logic [LINE_BITS-1:0]   lines_q, lines_d;
  logic [1:0]             text_len_q, text_len_d;
  logic                   text_cp_q, text_cp_d;

  // Result register.
  logic                   out_valid_q;
  lts_pkg::out_t          out_q, out_d;

  // Decode helpers.
  logic                   in_accept;
  lts_pkg::class_e        cur_class;
  lts_pkg::class_e        byte_cls;
  logic [COL_BITS-1:0]    char_idx_inc;
  logic [LINE_BITS-1:0]   line_next;
  logic                   is_quote;
  logic                   done;
  logic                   cleared;
  logic                   kept;
  lts_pkg::class_e        emit_class;
  logic [COL_BITS-1:0]    emit_col;

  assign in_accept  = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  // Saturating column step and wrapping line count.
  assign char_idx_inc = (char_idx_q == '1) ? char_idx_q : char_idx_q + COL_BITS'(1);
  assign line_next    = lines_q + LINE_BITS'(1);
  assign byte_cls     = lts_pkg::byte_class(in_data_i.ch);
  assign is_quote     = (in_data_i.ch == lts_pkg::ChQuote) ||
                        (in_data_i.ch == lts_pkg::ChDblQuote);

  // Token decision and next state for the item at the input.
  always_comb begin
    open_class_d = open_class_q;
    open_col_d   = open_col_q;
    char_idx_d   = char_idx_q;
    lines_d      = lines_q;
    text_len_d   = text_len_q;
    text_cp_d    = text_cp_q;
    done         = 1'b0;
    cleared      = 1'b0;
    kept         = 1'b0;
    emit_class   = open_class_q;
    emit_col     = open_col_q;
    cur_class    = open_class_q;

    if (in_data_i.line_end) begin
      // End of line: close what is open and return to the line start.
      if (char_idx_q != '0) begin
        if (open_class_q == lts_pkg::CL_STR) begin
          done = 1'b1;
        end else if (open_class_q == lts_pkg::CL_NONE) begin
          kept = 1'b1;
        end else begin
          done    = 1'b1;
          cleared = 1'b1;
          kept    = 1'b1;
        end
      end
      open_class_d = lts_pkg::CL_NONE;
      open_col_d   = COL_BITS'(1);
      char_idx_d   = '0;
      text_len_d   = 2'd0;
      text_cp_d    = 1'b0;
      lines_d      = line_next;
    end else begin
      if (open_class_q == lts_pkg::CL_NONE) begin
        cur_class = byte_cls;
      end
      emit_class = cur_class;

      if (is_quote) begin
        // A quote closes an open string, or else closes any open token and opens a new string.
        if (cur_class == lts_pkg::CL_STR) begin
          done      = 1'b1;
          cur_class = lts_pkg::CL_NONE;
        end else begin
          done       = (cur_class != lts_pkg::CL_NONE);
          cur_class  = lts_pkg::CL_STR;
          open_col_d = char_idx_inc;
        end
        text_len_d = 2'd0;
        text_cp_d  = 1'b0;
        cleared    = 1'b1;
      end else if (cur_class == lts_pkg::CL_STR) begin
        // Inside a string every byte is kept.
        text_cp_d  = (text_len_q == 2'd0) && (in_data_i.ch == lts_pkg::ChRParen);
        text_len_d = (text_len_q == 2'd2) ? text_len_q : text_len_q + 2'd1;
        kept       = 1'b1;
      end else if (in_data_i.ch == lts_pkg::ChSpace) begin
        // A space ends an open token.
        if (cur_class != lts_pkg::CL_NONE) begin
          done       = 1'b1;
          cur_class  = lts_pkg::CL_NONE;
          text_len_d = 2'd0;
          text_cp_d  = 1'b0;
          cleared    = 1'b1;
          open_col_d = char_idx_inc;
        end
      end else if ((byte_cls != cur_class && cur_class != lts_pkg::CL_NONE) ||
                   (text_cp_q && (in_data_i.ch == lts_pkg::ChComma ||
                                  in_data_i.ch == lts_pkg::ChRParen))) begin
        // A class change, or a comma or close paren after a lone close paren.
        done       = 1'b1;
        cur_class  = byte_cls;
        text_len_d = 2'd1;
        text_cp_d  = (in_data_i.ch == lts_pkg::ChRParen);
        cleared    = 1'b1;
        kept       = 1'b1;
        open_col_d = char_idx_inc;
      end else begin
        text_cp_d  = (text_len_q == 2'd0) && (in_data_i.ch == lts_pkg::ChRParen);
        text_len_d = (text_len_q == 2'd2) ? text_len_q : text_len_q + 2'd1;
        kept       = 1'b1;
      end
      open_class_d = cur_class;
      char_idx_d   = char_idx_inc;
    end
  end

  // Result fields; the token fields read zero when no token closes.
  always_comb begin
    out_d              = '0;
    out_d.token_done   = done;
    out_d.text_cleared = cleared;
    out_d.char_kept    = kept;
    if (done) begin
      out_d.token_class  = emit_class[1:0];
      out_d.token_line   = 32'(line_next);
      out_d.token_column = 16'(emit_col);
    end
  end

  // Token state registers, updated once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_class_q <= lts_pkg::CL_NONE;
      open_col_q   <= COL_BITS'(1);
      char_idx_q   <= '0;
      lines_q      <= '0;
      text_len_q   <= 2'd0;
      text_cp_q    <= 1'b0;
    end else if (in_accept) begin
      open_class_q <= open_class_d;
      open_col_q   <= open_col_d;
      char_idx_q   <= char_idx_d;
      lines_q      <= lines_d;
      text_len_q   <= text_len_d;
      text_cp_q    <= text_cp_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: sv/lts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line token splitter checker
// Port-level assertions on the splitter, attached to the splitter module by bind.
// ----------------------------------------------------------------------------
module lts_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire lts_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire lts_pkg::out_t out_data_o
);

  // A waiting input item holds its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("lts: waiting input item changed or dropped");

  // A result that is not taken stays, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("lts: stalled result item changed or dropped");

  // With no pending result the splitter takes a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("lts: input stalled with an empty result register");

  // Without a closed token the token fields read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.token_done |->
      out_data_o.token_class == 2'd0 && out_data_o.token_line == 32'd0 &&
      out_data_o.token_column == 16'd0)
    else $error("lts: token fields set without a token");

  // A closing string never keeps the byte or terminator that closes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_done &&
      {1'b0, out_data_o.token_class} == lts_pkg::CL_STR |-> !out_data_o.char_kept)
    else $error("lts: string close kept its terminating item");

endmodule

bind line_token_splitter lts_checker u_lts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

FILE: tb/line_token_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line token splitter testbench
// Drives directed lines, random tokenized lines with noise, and one long
// line into the splitter. Random idle bursts appear on both channels, but
// not during the long line. Every result is compared field by field against
// a cycle-free token model that is kept in the testbench.
// ----------------------------------------------------------------------------
module line_token_splitter_tb;

  localparam int unsigned CycleLimit    = 100000;
  localparam int unsigned RandomItems   = 680;
  localparam int unsigned LongLineBytes = 140;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  lts_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  lts_pkg::out_t out_data_o;

  // Token model state.
  lts_pkg::class_e tok_class;
  logic [15:0]     tok_column;
  logic [15:0]     byte_pos;
  logic [31:0]     lines_seen;
  logic [1:0]      text_len;
  logic            text_rparen;

  lts_pkg::out_t pending_results[$];
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  int unsigned   stall_left = 0;
  bit            idle_en = 1'b1;

  logic [7:0] op_chars [10] = '{lts_pkg::ChMinus, lts_pkg::ChGreater,
                                lts_pkg::ChEqual, lts_pkg::ChLParen,
                                lts_pkg::ChRParen, lts_pkg::ChComma,
                                lts_pkg::ChPlus, lts_pkg::ChLBrace,
                                lts_pkg::ChRBrace, lts_pkg::ChAmp};

  line_token_splitter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 100 MHz clock.
  always begin
    #5;
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token model
  // ---------------------------------------------------------------------------

  function automatic lts_pkg::class_e char_kind(input logic [7:0] c);
    lts_pkg::class_e k;
    if (c >= "0" && c <= "9") begin
      k = lts_pkg::CL_NUM;
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      k = lts_pkg::CL_NAME;
    end else begin
      k = lts_pkg::CL_NONE;
      foreach (op_chars[i]) begin
        if (c == op_chars[i]) begin
          k = lts_pkg::CL_OP;
        end
      end
    end
    return k;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Result fields of a token that closes with the given class.
  function automatic lts_pkg::out_t closed_token(input lts_pkg::class_e c);
    lts_pkg::out_t r;
    r = '0;
    r.token_done   = 1'b1;
    r.token_class  = c[1:0];
    r.token_line   = lines_seen + 32'd1;
    r.token_column = tok_column;
    return r;
  endfunction

  function automatic void append_text(input logic [7:0] c);
    text_rparen = (text_len == 2'd0 && c == lts_pkg::ChRParen);
    if (text_len < 2'd2) begin
      text_len = text_len + 2'd1;
    end
  endfunction

  // Works out the result of one item and advances the model state.
  function automatic lts_pkg::out_t next_token_result(input lts_pkg::in_t it);
    lts_pkg::out_t   r;
    lts_pkg::class_e oc;
    lts_pkg::class_e t;
    r  = '0;
    oc = (tok_class > lts_pkg::CL_NONE) ? lts_pkg::CL_NONE : tok_class;
    if (it.line_end) begin
      if (byte_pos != 16'd0) begin
        if (oc == lts_pkg::CL_STR) begin
          r = closed_token(oc);
        end else if (oc == lts_pkg::CL_NONE) begin
          r.char_kept = 1'b1;
        end else begin
          r = closed_token(oc);
          r.text_cleared = 1'b1;
          r.char_kept    = 1'b1;
        end
      end
      tok_class   = lts_pkg::CL_NONE;
      tok_column  = 16'd1;
      byte_pos    = 16'd0;
      text_len    = 2'd0;
      text_rparen = 1'b0;
      lines_seen  = lines_seen + 32'd1;
    end else begin
      t = char_kind(it.ch);
      if (oc == lts_pkg::CL_NONE) begin
        oc = t;
      end
      if (it.ch == lts_pkg::ChQuote || it.ch == lts_pkg::ChDblQuote) begin
        // A quote closes an open string, or else closes any token and opens one.
        if (oc == lts_pkg::CL_STR) begin
          r  = closed_token(oc);
          oc = lts_pkg::CL_NONE;
        end else begin
          if (oc != lts_pkg::CL_NONE) begin
            r = closed_token(oc);
          end
          oc         = lts_pkg::CL_STR;
          tok_column = sat_inc(byte_pos);
        end
        text_len       = 2'd0;
        text_rparen    = 1'b0;
        r.text_cleared = 1'b1;
      end else if (oc == lts_pkg::CL_STR) begin
        append_text(it.ch);
        r.char_kept = 1'b1;
      end else if (it.ch == lts_pkg::ChSpace) begin
        if (oc != lts_pkg::CL_NONE) begin
          r              = closed_token(oc);
          oc             = lts_pkg::CL_NONE;
          text_len       = 2'd0;
          text_rparen    = 1'b0;
          r.text_cleared = 1'b1;
          tok_column     = sat_inc(byte_pos);
        end
      end else if ((t != oc && oc != lts_pkg::CL_NONE) ||
                   (text_rparen && (it.ch == lts_pkg::ChComma ||
                                    it.ch == lts_pkg::ChRParen))) begin
        // Class change, or a close paren followed by a comma or close paren.
        r              = closed_token(oc);
        oc             = t;
        text_len       = 2'd1;
        text_rparen    = (it.ch == lts_pkg::ChRParen);
        r.text_cleared = 1'b1;
        r.char_kept    = 1'b1;
        tok_column     = sat_inc(byte_pos);
      end else begin
        append_text(it.ch);
        r.char_kept = 1'b1;
      end
      tok_class = oc;
      byte_pos  = sat_inc(byte_pos);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result, then predict each accepted item.
  always @(posedge clk_i) begin : result_check
    lts_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0h",
                   $time, out_data_o);
        end else begin
          want = pending_results.pop_front();
          check_field("token_done", 32'(want.token_done), 32'(out_data_o.token_done));
          check_field("token_class", 32'(want.token_class),
                      32'(out_data_o.token_class));
          check_field("token_line", want.token_line, out_data_o.token_line);
          check_field("token_column", 32'(want.token_column),
                      32'(out_data_o.token_column));
          check_field("text_cleared", 32'(want.text_cleared),
                      32'(out_data_o.text_cleared));
          check_field("char_kept", 32'(want.char_kept), 32'(out_data_o.char_kept));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_results = {pending_results, next_token_result(in_data_i)};
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else if (idle_en && rst_ni && $urandom_range(0, 7) == 0) begin
      stall_left  = $urandom_range(0, 11);
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Sends one item, optionally after an idle burst; returns at a falling edge.
  task automatic send_item(input lts_pkg::in_t it);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap        = $urandom_range(1, 12);
      in_valid_i = 1'b0;
      in_data_i  = lts_pkg::in_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(lts_pkg::in_t'{ch: c, line_end: 1'b0});
  endtask

  // The byte field of a line end carries random content.
  task automatic send_eol();
    send_item(lts_pkg::in_t'{ch: 8'($urandom), line_end: 1'b1});
  endtask

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  // Sends one random token or separator and reports how many bytes it took.
  task automatic send_random_token(output int unsigned n);
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 4);
    n    = 0;
    case (kind)
      0, 1: begin
        repeat (len) send_char(8'("0" + $urandom_range(0, 9)));
        n = len;
      end
      2, 3: begin
        repeat (len) send_char(pick_letter());
        n = len;
      end
      4, 5: begin
        repeat (len) send_char(op_chars[$urandom_range(0, 9)]);
        n = len;
      end
      6: begin
        // String with random content, sometimes left open.
        send_char($urandom_range(0, 1) ? lts_pkg::ChQuote : lts_pkg::ChDblQuote);
        repeat (len - 1) send_char(8'($urandom_range(0, 255)));
        n = len;
        if ($urandom_range(0, 3) != 0) begin
          send_char($urandom_range(0, 1) ? lts_pkg::ChQuote : lts_pkg::ChDblQuote);
          n++;
        end
      end
      7: begin
        send_char(lts_pkg::ChRParen);
        send_char($urandom_range(0, 1) ? lts_pkg::ChComma : lts_pkg::ChRParen);
        n = 2;
      end
      8: begin
        send_char(lts_pkg::ChSpace);
        n = 1;
      end
      default: begin
        send_char(8'($urandom_range(0, 255)));
        n = 1;
      end
    endcase
  endtask

  // Empty line, unclassed bytes, open string at line end, number at line end,
  // closing quote followed by a name, space column and close paren pairs.
  task automatic test_directed();
    send_eol();
    send_char(8'hFF);
    send_char(8'h80);
    send_eol();
    send_char(lts_pkg::ChQuote);
    send_char("a");
    send_char("b");
    send_eol();
    send_char("9");
    send_char("0");
    send_eol();
    send_char(lts_pkg::ChQuote);
    send_char("x");
    send_char(lts_pkg::ChQuote);
    send_char("q");
    send_char(lts_pkg::ChSpace);
    send_char(lts_pkg::ChLParen);
    send_char(lts_pkg::ChRParen);
    send_char(lts_pkg::ChRParen);
    send_char(lts_pkg::ChComma);
    send_char(lts_pkg::ChAmp);
    send_char(lts_pkg::ChDblQuote);
    send_item(lts_pkg::in_t'{ch: 8'h00, line_end: 1'b1});
  endtask

  // Mostly well formed random lines, with some lines of raw noise.
  task automatic test_random();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, 8);
        repeat (n) send_char(8'($urandom_range(0, 255)));
        sent += n;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_random_token(n);
          sent += n;
        end
      end
      send_eol();
      sent++;
    end
  endtask

  // A long line of back to back tokens ending in spaces, a name, a string and a number, then a short line.
  task automatic test_long_line();
    int unsigned total;
    int unsigned n;
    total = 0;
    while (total < LongLineBytes) begin
      send_random_token(n);
      total += n;
    end
    send_char(lts_pkg::ChSpace);
    send_char("a");
    send_char("b");
    send_char(lts_pkg::ChSpace);
    send_char(lts_pkg::ChQuote);
    send_char("z");
    send_char(lts_pkg::ChQuote);
    send_char("7");
    send_eol();
    send_char("q");
    send_eol();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    tok_class   = lts_pkg::CL_NONE;
    tok_column  = 16'd1;
    byte_pos    = 16'd0;
    lines_seen  = 32'd0;
    text_len    = 2'd0;
    text_rparen = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random();
    // The last part of the run has no idling on either side.
    idle_en = 1'b0;
    test_long_line();
    in_valid_i = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lts_pkg.sv
sv/line_token_splitter.sv
sv/lts_checker.sv
tb/line_token_splitter_tb.sv
